>>> hw/rtl/ysp_pkg.sv
// ----------------------------------------------------------------------------
// ysp_pkg
// Shared types and constants of the YUYV to ARGB screen placer: register
// indexes and resets, colour coefficients in Q8, and the pipeline control.
// ----------------------------------------------------------------------------
`default_nettype none

package ysp_pkg;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_SCREEN_WIDTH = 3'd2,
    CFG_ORIGIN_X     = 3'd3,
    CFG_ORIGIN_Y     = 3'd4
  } cfg_idx_e;

  localparam int FrameWidthW  = 13;
  localparam int FrameHeightW = 13;
  localparam int ScreenWidthW = 14;
  localparam int OriginW      = 13;

  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 13'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd480;
  localparam logic [ScreenWidthW-1:0] ScreenWidthRst = 14'd1920;
  localparam logic [OriginW-1:0]      OriginRst      = 13'd0;

  typedef struct packed {
    logic [FrameWidthW-1:0]  frame_width;
    logic [FrameHeightW-1:0] frame_height;
    logic [ScreenWidthW-1:0] screen_width;
    logic [OriginW-1:0]      origin_x;
    logic [OriginW-1:0]      origin_y;
  } cfg_t;

  // Frame walk
  localparam int ColW  = 11;
  localparam int RowW  = 12;
  localparam int AddrW = 26;

  // Colour maths, Q8
  localparam int LumaOffset = 16;
  localparam int CoefY      = 298;
  localparam int CoefRv     = 409;
  localparam int CoefGv     = 208;
  localparam int CoefGu     = 101;
  localparam int CoefBu     = 517;
  localparam int ClipTop    = 254 * 256;

  localparam int LumaTermW = 18;
  localparam int RedTermW  = 17;
  localparam int GrnTermW  = 17;
  localparam int BluTermW  = 18;
  localparam int SumW      = 19;

  localparam logic [7:0] Alpha = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Stage load strobes shared by all units
  typedef struct packed {
    logic load_a;
    logic load_b;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ysp_lane.sv
// ----------------------------------------------------------------------------
// ysp_lane
// One pixel lane: scales its luma sample, adds the shared chroma terms and
// clips each colour sum to eight bits. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ysp_lane
  import ysp_pkg::*;
(
  input  wire                          clk_i,
  input  pipe_ctl_t                    ctl_i,
  input  wire  [7:0]                   luma_i,
  input  wire  signed [RedTermW-1:0]   red_term_i,
  input  wire  signed [GrnTermW-1:0]   grn_term_i,
  input  wire  signed [BluTermW-1:0]   blu_term_i,
  output pixel_t                       pixel_o
);

  logic signed [8:0]           luma_off;
  logic signed [LumaTermW-1:0] luma_term_d, luma_term_q;
  logic signed [SumW-1:0]      red_sum, grn_sum, blu_sum;
  pixel_t                      pixel_d, pixel_q;

  function automatic logic [7:0] clip_q8(input logic signed [SumW-1:0] s);
    logic [7:0] res;
    if (s < 0) begin
      res = 8'd0;
    end else if (s > SumW'(ClipTop)) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  // Scale luma, offset removed
  assign luma_off    = $signed({1'b0, luma_i}) - 9'(LumaOffset);
  assign luma_term_d = LumaTermW'(luma_off) * LumaTermW'(CoefY);

  // Add chroma and clip
  assign red_sum = SumW'(luma_term_q) + SumW'(red_term_i);
  assign grn_sum = SumW'(luma_term_q) - SumW'(grn_term_i);
  assign blu_sum = SumW'(luma_term_q) + SumW'(blu_term_i);

  always_comb begin
    pixel_d.red   = clip_q8(red_sum);
    pixel_d.green = clip_q8(grn_sum);
    pixel_d.blue  = clip_q8(blu_sum);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_a) begin
      luma_term_q <= luma_term_d;
    end
    if (ctl_i.load_b) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

>>> hw/rtl/ysp_place.sv
// ----------------------------------------------------------------------------
// ysp_place
// Frame walk and placement: pair-column and row counters, row and frame end
// flags, and the screen word address of the pair's first pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ysp_place
  import ysp_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  cfg_t              cfg_i,
  output logic [AddrW-1:0]  addr_o,
  output logic              row_end_o,
  output logic              frame_end_o
);

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [11:0]      pairs_raw;
  logic [ColW-1:0]  last_col;
  logic [RowW-1:0]  last_row;
  logic             row_end, frame_end;
  logic [13:0]      row_sum;
  logic [27:0]      row_prod;
  logic [AddrW-1:0] row_base_q;
  logic [13:0]      col_off_d, col_off_q;
  logic             row_end_a_q, frame_end_a_q;
  logic [AddrW-1:0] addr_q;
  logic             row_end_q, frame_end_q;

  // Clamp frame size to the last pair and last row
  assign pairs_raw = cfg_i.frame_width[FrameWidthW-1:1];

  always_comb begin
    if (pairs_raw == 12'd0) begin
      last_col = '0;
    end else if (pairs_raw > 12'd2048) begin
      last_col = '1;
    end else begin
      last_col = ColW'(pairs_raw - 12'd1);
    end
    if (cfg_i.frame_height == '0) begin
      last_row = '0;
    end else if (cfg_i.frame_height > 13'd4096) begin
      last_row = '1;
    end else begin
      last_row = RowW'(cfg_i.frame_height - 13'd1);
    end
  end

  assign row_end   = (col_q >= last_col);
  assign frame_end = row_end && (row_q >= last_row);

  // Advance the walk on every accepted item
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (ctl_i.load_a) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Row base by one multiply, column offset beside it
  assign row_sum   = 14'(cfg_i.origin_y) + 14'(row_q);
  assign row_prod  = 28'(row_sum) * 28'(cfg_i.screen_width);
  assign col_off_d = 14'(cfg_i.origin_x) + 14'({col_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_a) begin
      row_base_q    <= row_prod[AddrW-1:0];
      col_off_q     <= col_off_d;
      row_end_a_q   <= row_end;
      frame_end_a_q <= frame_end;
    end
    if (ctl_i.load_b) begin
      addr_q      <= row_base_q + AddrW'(col_off_q);
      row_end_q   <= row_end_a_q;
      frame_end_q <= frame_end_a_q;
    end
  end

  assign addr_o      = addr_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

>>> hw/rtl/yuyv_to_argb_screen_placer.sv
// ----------------------------------------------------------------------------
// yuyv_to_argb_screen_placer
// YUYV 4:2:2 macropixel to two ARGB words, placed in a screen buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one YUYV macropixel per item (Y0, U, Y1, V).
//   Output stream m_axis: one item per input item, carrying both ARGB words
//   (alpha 0xFF) and the screen word address of the first pixel; tlast marks
//   the last pair of a frame row, tuser the last pair of the frame.
//   Configuration: write cfg_idx_i/cfg_data_i with cfg_we_i high, only while
//   no item is in flight. Registers: frame width, frame height, screen width,
//   origin column, origin row.
//   Input items pass stage A, then stage B. Throughput: one item per cycle
//   while the output is not stalled, set by the two-stage pipeline in which
//   two pixel lanes and the placement unit (one 14x14 multiply) run in step.
//   Stall: each stage loads when the stage after it is empty or drains, so
//   a stalled receiver holds the output item and the input keeps being
//   taken until both stages are full.
//   Reset: clears the frame walk counters and stage valids and loads the
//   default frame and screen geometry; the first item goes to the frame's
//   top left pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_argb_screen_placer
  import ysp_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Input stream
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [31:0]         s_axis_tdata,   // luma_first, chroma_blue,
                                              // luma_second, chroma_red
  // Output stream
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [95:0]         m_axis_tdata,   // argb_first, argb_second,
                                              // screen_address, zero pad
  output logic                m_axis_tlast,   // row_end
  output logic                m_axis_tuser,   // frame_end
  // Configuration writes
  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  logic       valid_a_q, valid_b_q;
  logic       ready_a, ready_b;
  pipe_ctl_t  ctl;

  logic [7:0]                 luma_first, chroma_blue, luma_second, chroma_red;
  logic signed [8:0]          u_off, v_off;
  logic signed [RedTermW-1:0] red_term_d, red_term_q;
  logic signed [GrnTermW-1:0] grn_term_d, grn_term_q;
  logic signed [BluTermW-1:0] blu_term_d, blu_term_q;
  pixel_t                     pix_first, pix_second;
  logic [AddrW-1:0]           addr;
  logic                       row_end, frame_end;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= FrameWidthRst;
      cfg_q.frame_height <= FrameHeightRst;
      cfg_q.screen_width <= ScreenWidthRst;
      cfg_q.origin_x     <= OriginRst;
      cfg_q.origin_y     <= OriginRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[FrameWidthW-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[FrameHeightW-1:0];
        CFG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data_i[ScreenWidthW-1:0];
        CFG_ORIGIN_X:     cfg_q.origin_x     <= cfg_data_i[OriginW-1:0];
        CFG_ORIGIN_Y:     cfg_q.origin_y     <= cfg_data_i[OriginW-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: load when the next stage is empty or drains
  assign ready_b       = !valid_b_q || m_axis_tready;
  assign ready_a       = !valid_a_q || ready_b;
  assign s_axis_tready = ready_a;
  assign ctl.load_a    = s_axis_tvalid && ready_a;
  assign ctl.load_b    = valid_a_q && ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= s_axis_tvalid;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  // Unpack the macropixel
  assign luma_first  = s_axis_tdata[7:0];
  assign chroma_blue = s_axis_tdata[15:8];
  assign luma_second = s_axis_tdata[23:16];
  assign chroma_red  = s_axis_tdata[31:24];

  // Shared chroma terms, offset 128 removed by flipping the top bit and
  // extending it as the sign
  assign u_off      = {~chroma_blue[7], ~chroma_blue[7], chroma_blue[6:0]};
  assign v_off      = {~chroma_red[7], ~chroma_red[7], chroma_red[6:0]};
  assign red_term_d = RedTermW'(v_off) * RedTermW'(CoefRv);
  assign grn_term_d = GrnTermW'(v_off) * GrnTermW'(CoefGv)
                    + GrnTermW'(u_off) * GrnTermW'(CoefGu);
  assign blu_term_d = BluTermW'(u_off) * BluTermW'(CoefBu);

  always_ff @(posedge clk_i) begin
    if (ctl.load_a) begin
      red_term_q <= red_term_d;
      grn_term_q <= grn_term_d;
      blu_term_q <= blu_term_d;
    end
  end

  // Pixel lanes
  ysp_lane u_lane_first (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .luma_i     (luma_first),
    .red_term_i (red_term_q),
    .grn_term_i (grn_term_q),
    .blu_term_i (blu_term_q),
    .pixel_o    (pix_first)
  );

  ysp_lane u_lane_second (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .luma_i     (luma_second),
    .red_term_i (red_term_q),
    .grn_term_i (grn_term_q),
    .blu_term_i (blu_term_q),
    .pixel_o    (pix_second)
  );

  // Placement
  ysp_place u_place (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_i       (cfg_q),
    .addr_o      (addr),
    .row_end_o   (row_end),
    .frame_end_o (frame_end)
  );

  // Merge lanes and placement into the output item
  assign m_axis_tvalid = valid_b_q;
  assign m_axis_tdata  = {6'd0, addr,
                          Alpha, pix_second.red, pix_second.green, pix_second.blue,
                          Alpha, pix_first.red, pix_first.green, pix_first.blue};
  assign m_axis_tlast  = row_end;
  assign m_axis_tuser  = frame_end;

endmodule

`default_nettype wire

>>> hw/rtl/ysp_checker.sv
// ----------------------------------------------------------------------------
// ysp_checker
// Port-level checks of the screen placer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ysp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [95:0] m_axis_tdata,
  input wire        m_axis_tlast,
  input wire        m_axis_tuser
);

  // Hold an offered output item until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // Frame end is always also a row end
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without row end");

  // Both pixels carry an opaque alpha byte
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'hFF) && (m_axis_tdata[63:56] == 8'hFF))
    else $error("alpha byte not opaque");

  // An empty output fills only with an input item taken and passed through both stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output item without matching input item");

endmodule

bind yuyv_to_argb_screen_placer ysp_checker u_ysp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> dv/ysp_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ysp_stream_checker
// Watches the pixel, result and register channels of the screen placer. It
// keeps its own copy of the geometry and of the frame walk, works out the
// ARGB pair and screen address for every accepted macropixel, and checks
// each result item against the oldest pending pair.
// ----------------------------------------------------------------------------
module ysp_stream_checker
  import ysp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel stream into the block
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [31:0]         s_tdata_i,   // luma_first, chroma_blue,
                                           // luma_second, chroma_red
  // Result stream out of the block
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [95:0]         m_tdata_i,   // argb_first, argb_second,
                                           // screen_address, zero pad
  input  logic                m_tlast_i,   // row_end
  input  logic                m_tuser_i,   // frame_end
  // Register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Status towards the stimulus side
  output int                  errors_o,
  output int                  pending_o,
  output int                  row_ends_o,
  output int                  frame_ends_o
);

  localparam int ChromaMid = 128;
  localparam int MaxPairs  = 2048;
  localparam int MaxRows   = 4096;

  typedef struct packed {
    logic [31:0]      argb_first;
    logic [31:0]      argb_second;
    logic [AddrW-1:0] addr;
    logic             row_end;
    logic             frame_end;
  } placed_pair_t;

  placed_pair_t pairs_due[$];

  // Geometry as last written
  logic [FrameWidthW-1:0]  frame_w;
  logic [FrameHeightW-1:0] frame_h;
  logic [ScreenWidthW-1:0] screen_w;
  logic [OriginW-1:0]      org_x;
  logic [OriginW-1:0]      org_y;

  // Frame walk
  logic [ColW-1:0] pair_col;
  logic [RowW-1:0] row_idx;

  int err_n;
  int row_end_n;
  int frame_end_n;

  assign errors_o     = err_n;
  assign row_ends_o   = row_end_n;
  assign frame_ends_o = frame_end_n;

  // Clip a Q8 sum to an 8-bit channel
  function automatic logic [7:0] clamp_q8(int s);
    if (s < 0) return 8'd0;
    if (s > ClipTop) return 8'd255;
    return 8'(s >>> 8);
  endfunction

  function automatic logic [31:0] to_argb(logic [7:0] luma, int ut, int vt);
    int yt;
    yt = CoefY * (int'(luma) - LumaOffset);
    return {Alpha, clamp_q8(yt + CoefRv * vt),
            clamp_q8(yt - CoefGv * vt - CoefGu * ut),
            clamp_q8(yt + CoefBu * ut)};
  endfunction

  // Colour and placement of one macropixel at the current walk position
  function automatic placed_pair_t place_pair(logic [31:0] d);
    placed_pair_t p;
    int           ut;
    int           vt;
    int           pairs;
    int           rows;
    longint       a;
    ut = int'(d[15:8]) - ChromaMid;
    vt = int'(d[31:24]) - ChromaMid;
    pairs = int'(frame_w) >> 1;
    if (pairs == 0) pairs = 1;
    if (pairs > MaxPairs) pairs = MaxPairs;
    rows = int'(frame_h);
    if (rows == 0) rows = 1;
    if (rows > MaxRows) rows = MaxRows;
    a = longint'(org_x) + (longint'(org_y) + longint'(row_idx)) * longint'(screen_w)
      + 2 * longint'(pair_col);
    p.argb_first  = to_argb(d[7:0], ut, vt);
    p.argb_second = to_argb(d[23:16], ut, vt);
    p.addr        = a[AddrW-1:0];
    p.row_end     = int'(pair_col) >= pairs - 1;
    p.frame_end   = p.row_end && (int'(row_idx) >= rows - 1);
    return p;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_n++;
    $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    placed_pair_t want;
    if (!rst_ni) begin
      frame_w     <= FrameWidthRst;
      frame_h     <= FrameHeightRst;
      screen_w    <= ScreenWidthRst;
      org_x       <= OriginRst;
      org_y       <= OriginRst;
      pair_col    <= '0;
      row_idx     <= '0;
      pending_o   <= 0;
      err_n       = 0;
      row_end_n   = 0;
      frame_end_n = 0;
      pairs_due.delete();
    end else begin
      // Take register writes, upper bits dropped
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  frame_w  <= cfg_data_i[FrameWidthW-1:0];
          CFG_FRAME_HEIGHT: frame_h  <= cfg_data_i[FrameHeightW-1:0];
          CFG_SCREEN_WIDTH: screen_w <= cfg_data_i[ScreenWidthW-1:0];
          CFG_ORIGIN_X:     org_x    <= cfg_data_i[OriginW-1:0];
          CFG_ORIGIN_Y:     org_y    <= cfg_data_i[OriginW-1:0];
          default: ;
        endcase
      end

      // Compare a result item with the oldest pending pair
      if (m_tvalid_i && m_tready_i) begin
        if (pairs_due.size() == 0) begin
          flag_mismatch("unrequested result", m_tdata_i[31:0], '0);
        end else begin
          want = pairs_due.pop_front();
          if (m_tdata_i[31:0] !== want.argb_first)
            flag_mismatch("argb_first", m_tdata_i[31:0], want.argb_first);
          if (m_tdata_i[63:32] !== want.argb_second)
            flag_mismatch("argb_second", m_tdata_i[63:32], want.argb_second);
          if (m_tdata_i[64 +: AddrW] !== want.addr)
            flag_mismatch("screen_address", 32'(m_tdata_i[64 +: AddrW]), 32'(want.addr));
          if (m_tdata_i[95:64+AddrW] !== '0)
            flag_mismatch("tdata pad", 32'(m_tdata_i[95:64+AddrW]), '0);
          if (m_tlast_i !== want.row_end)
            flag_mismatch("row_end", 32'(m_tlast_i), 32'(want.row_end));
          if (m_tuser_i !== want.frame_end)
            flag_mismatch("frame_end", 32'(m_tuser_i), 32'(want.frame_end));
          if (want.row_end) row_end_n++;
          if (want.frame_end) frame_end_n++;
        end
      end

      // Predict an accepted macropixel and advance the walk
      if (s_tvalid_i && s_tready_i) begin
        want = place_pair(s_tdata_i);
        pairs_due.push_back(want);
        if (want.frame_end) begin
          pair_col <= '0;
          row_idx  <= '0;
        end else if (want.row_end) begin
          pair_col <= '0;
          row_idx  <= row_idx + 1'b1;
        end else begin
          pair_col <= pair_col + 1'b1;
        end
      end

      pending_o <= pairs_due.size();
    end
  end

endmodule

>>> dv/yuyv_to_argb_screen_placer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuyv_to_argb_screen_placer_tb
// Drives macropixels and geometry writes into the screen placer with random
// gaps on the input and random stalls on the output. A directed opening hits
// colour clipping, geometry saturation, address wrap and mid-frame changes;
// random phases then walk many small frames under changing geometry.
// ----------------------------------------------------------------------------
module yuyv_to_argb_screen_placer_tb;
  import ysp_pkg::*;

  localparam int HalfPeriod   = 6;
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 6;
  localparam int RandPhases   = 12;
  localparam int PhaseItems   = 100;
  localparam int MaxIdle      = 11;

  localparam logic [CfgIdxW-1:0] SpareIdxLo = 3'd5;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 3'd7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [95:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int errors;
  int pending;
  int row_ends;
  int frame_ends;

  int unsigned cycles     = 0;
  int          pairs_sent = 0;
  int          settings_n = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int          rx_hold    = 0;
  int          rx_draw;

  always #(HalfPeriod) clk_i = ~clk_i;

  yuyv_to_argb_screen_placer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  ysp_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending),
    .row_ends_o   (row_ends),
    .frame_ends_o (frame_ends)
  );

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending);
      $display("** yuyv_to_argb_screen_placer: FAILED **");
      $finish;
    end
  end

  // Result receiver: hold tready low for a random count after each item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_draw = rx_idle_on ? $urandom_range(0, MaxIdle) : 0;
      rx_hold       <= rx_draw;
      m_axis_tready <= (rx_draw == 0);
    end else if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= (rx_hold == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one macropixel and hold it until taken
  task automatic push_pair(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, y1, u, y0};
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
  endtask

  // Stop sending and wait until every pending result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Write the whole geometry, optionally poking an unused index too
  task automatic set_geometry(int fw, int fh, int sw, int ox, int oy, bit spare);
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(fw));
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(fh));
    write_reg(CFG_SCREEN_WIDTH, CfgDataW'(sw));
    write_reg(CFG_ORIGIN_X, CfgDataW'(ox));
    write_reg(CFG_ORIGIN_Y, CfgDataW'(oy));
    if (spare) write_reg(CfgIdxW'($urandom_range(SpareIdxLo, SpareIdxHi)), CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    settings_n++;
  endtask

  // Byte biased towards the clipping corners
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Occasionally set bit 13, which the 13-bit registers drop
  function automatic int junk_top();
    return ($urandom_range(0, 3) == 0) ? 32'h2000 : 0;
  endfunction

  initial begin
    int fw;
    int fh;
    int sw;
    int ox;
    int oy;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Colour extremes on the reset geometry
    push_pair(8'd0, 8'd0, 8'd0, 8'd0);
    push_pair(8'd255, 8'd255, 8'd255, 8'd255);
    push_pair(8'd16, 8'd128, 8'd16, 8'd128);
    push_pair(8'd235, 8'd128, 8'd235, 8'd128);
    push_pair(8'd255, 8'd0, 8'd0, 8'd255);
    push_pair(8'd0, 8'd255, 8'd255, 8'd0);
    push_pair(8'd128, 8'd0, 8'd128, 8'd255);
    push_pair(8'd128, 8'd255, 8'd128, 8'd0);
    drain_results();

    // Saturated geometry with the address running past the top
    set_geometry(8191, 8191, 16383, 8191, 8191, 1'b1);
    push_pair(8'd255, 8'd128, 8'd0, 8'd128);
    push_pair(8'd81, 8'd90, 8'd145, 8'd240);
    push_pair(8'd41, 8'd240, 8'd210, 8'd16);
    drain_results();

    // Odd width, zero height: walk is past the new row end
    set_geometry(5, 0, 1920, 0, 0, 1'b0);
    repeat (3) push_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain_results();

    // Width below two and a zero screen width
    set_geometry(1, 2, 0, 10, 3, 1'b0);
    repeat (4) push_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain_results();

    set_geometry(0, 4096, 1, 4096, 0, 1'b0);
    repeat (2) push_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    drain_results();

    // Random phases; the walk carries over between them
    for (int ph = 0; ph < RandPhases; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        fw = ($urandom_range(0, 1) != 0) ? 8191 : 4096 + $urandom_range(0, 1);
        fh = ($urandom_range(0, 1) != 0) ? 8191 : $urandom_range(0, 1);
        sw = ($urandom_range(0, 1) != 0) ? 16383 : 0;
        ox = ($urandom_range(0, 1) != 0) ? 8191 : 0;
        oy = ($urandom_range(0, 1) != 0) ? 8191 : 0;
      end else begin
        fw = $urandom_range(0, 24) | junk_top();
        fh = $urandom_range(0, 6) | junk_top();
        sw = $urandom_range(0, 16383);
        ox = $urandom_range(0, 8191) | junk_top();
        oy = $urandom_range(0, 8191) | junk_top();
      end
      set_geometry(fw, fh, sw, ox, oy, ($urandom_range(0, 2) == 0));

      if (ph == 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
      end else if (ph == 2) begin
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end

      for (int n = 0; n < PhaseItems; n++) begin
        // Hold off once mid-phase until the output side has caught up
        if (ph == 3 && n == PhaseItems / 2) drain_results();
        push_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
      drain_results();
    end

    $display("Sent %0d macropixels over %0d geometry settings", pairs_sent, settings_n);
    $display("Checked %0d row ends and %0d frame ends", row_ends, frame_ends);
    if (errors == 0) begin
      $display("** yuyv_to_argb_screen_placer: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** yuyv_to_argb_screen_placer: FAILED **");
    end
    $finish;
  end

endmodule
